// ===== rtl/lnls_pkg.sv =====
// ----------------------------------------------------------------------------
// lnls_pkg: shared types and scan functions for the line number/label scanner
// Holds the transfer payload types, the character classifier and the
// per-character step of the prefix recognizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lnls_pkg;

    // Line geometry: offsets are clamped to LINE_MAX-1.
    localparam int LINE_MAX = 4096;
    localparam int POS_W    = $clog2(LINE_MAX);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

    // Configuration register indexes and reset values.
    localparam logic CFG_MAX_DIGITS = 1'b0;
    localparam logic CFG_MAX_LABEL  = 1'b1;
    localparam logic [3:0] MAX_DIGITS_RST = 4'd5;
    localparam logic [5:0] MAX_LABEL_RST  = 6'd31;

    // Verdict codes.
    localparam logic [2:0] OC_NONE  = 3'd0;
    localparam logic [2:0] OC_NUM   = 3'd1;
    localparam logic [2:0] OC_LABEL = 3'd2;
    localparam logic [2:0] OC_BOTH  = 3'd3;
    localparam logic [2:0] OC_BAD   = 3'd4;

    // Character codes that the classifier tests for.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        CL_OTHER = 3'd0,
        CL_WS    = 3'd1,
        CL_DIGIT = 3'd2,
        CL_ALPHA = 3'd3,
        CL_UNDER = 3'd4,
        CL_COLON = 3'd5
    } t_cls;

    typedef enum logic [4:0] {
        PH_LEAD  = 5'b00001,
        PH_NUM   = 5'b00010,
        PH_GAP   = 5'b00100,
        PH_LABEL = 5'b01000,
        PH_LTAIL = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [2:0]       outcome;
        logic [POS_W-1:0] number_start;
        logic [3:0]       number_len;
        logic [POS_W-1:0] label_start;
        logic [5:0]       label_len;
        logic [POS_W-1:0] resume_pos;
    } t_result;

    typedef struct packed {
        t_phase           phase;
        logic [POS_W-1:0] position;
        logic [5:0]       run_count;
        logic [POS_W-1:0] nstart;
        logic [3:0]       nlen;
        logic [POS_W-1:0] lstart;
        logic             decided;
        logic [2:0]       oc;
        logic [POS_W-1:0] resume;
        logic [5:0]       llen;
    } t_line_state;

    localparam t_line_state LINE_RST = '{
        phase:     PH_LEAD,
        position:  '0,
        run_count: '0,
        nstart:    '0,
        nlen:      '0,
        lstart:    '0,
        decided:   1'b0,
        oc:        OC_NONE,
        resume:    '0,
        llen:      '0
    };

    // Character class of one byte.
    function automatic t_cls classify(input logic [7:0] c);
        t_cls r;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            r = CL_WS;
        end else if (c >= CH_0 && c <= CH_9) begin
            r = CL_DIGIT;
        end else if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)) begin
            r = CL_ALPHA;
        end else if (c == CH_UNDER) begin
            r = CL_UNDER;
        end else if (c == CH_COLON) begin
            r = CL_COLON;
        end else begin
            r = CL_OTHER;
        end
        return r;
    endfunction

    // Lock in the verdict for the line.
    function automatic t_line_state finish(input t_line_state s, input logic [2:0] oc,
                                           input logic [POS_W-1:0] resume,
                                           input logic [5:0] llen);
        t_line_state r;
        r         = s;
        r.decided = 1'b1;
        r.oc      = oc;
        r.resume  = resume;
        r.llen    = llen;
        return r;
    endfunction

    // Start a label at the given offset, or reject it when labels are disabled.
    function automatic t_line_state begin_label(input t_line_state s,
                                                input logic [POS_W-1:0] pos,
                                                input logic [5:0] max_label,
                                                input logic [2:0] only);
        t_line_state r;
        r        = s;
        r.lstart = pos;
        if (max_label == '0) begin
            r = finish(r, only, pos, '0);
        end else begin
            r.run_count = 6'd1;
            r.phase     = PH_LABEL;
        end
        return r;
    endfunction

    // One character step of the recognizer.
    function automatic t_line_state feed(input t_line_state s, input t_cls cl,
                                         input logic [POS_W-1:0] pos,
                                         input logic [3:0] max_digits,
                                         input logic [5:0] max_label);
        t_line_state r;
        logic [2:0]  only;
        logic [2:0]  with_label;
        logic        label_char;
        r          = s;
        only       = (s.nlen != '0) ? OC_NUM : OC_NONE;
        with_label = (s.nlen != '0) ? OC_BOTH : OC_LABEL;
        label_char = (cl == CL_ALPHA) || (cl == CL_DIGIT) || (cl == CL_UNDER);
        unique case (s.phase)
            PH_LEAD: begin
                if (cl == CL_WS) begin
                    r = s;
                end else if (cl == CL_DIGIT) begin
                    r.nstart = pos;
                    if (max_digits == '0) begin
                        r = finish(r, OC_BAD, pos, '0);
                    end else begin
                        r.run_count = 6'd1;
                        r.phase     = PH_NUM;
                    end
                end else if (cl == CL_ALPHA) begin
                    r = begin_label(s, pos, max_label, only);
                end else begin
                    r = finish(s, OC_NONE, pos, '0);
                end
            end
            PH_NUM: begin
                if (cl == CL_DIGIT) begin
                    if (s.run_count < {2'b00, max_digits}) begin
                        r.run_count = s.run_count + 6'd1;
                    end else begin
                        r = finish(s, OC_BAD, s.nstart, '0);
                    end
                end else if (cl == CL_WS) begin
                    r.nlen      = s.run_count[3:0];
                    r.run_count = '0;
                    r.phase     = PH_GAP;
                end else begin
                    r = finish(s, OC_BAD, s.nstart, '0);
                end
            end
            PH_GAP: begin
                if (cl == CL_WS) begin
                    r = s;
                end else if (cl == CL_ALPHA) begin
                    r = begin_label(s, pos, max_label, only);
                end else begin
                    r = finish(s, only, pos, '0);
                end
            end
            PH_LABEL: begin
                if (label_char) begin
                    if (s.run_count < max_label) begin
                        r.run_count = s.run_count + 6'd1;
                    end else begin
                        r = finish(s, only, s.lstart, '0);
                    end
                end else if (cl == CL_WS) begin
                    r.phase = PH_LTAIL;
                end else if (cl == CL_COLON) begin
                    r = finish(s, with_label, pos + POS_W'(1), s.run_count);
                end else begin
                    r = finish(s, only, s.lstart, '0);
                end
            end
            PH_LTAIL: begin
                if (cl == CL_WS) begin
                    r = s;
                end else if (cl == CL_COLON) begin
                    r = finish(s, with_label, pos + POS_W'(1), s.run_count);
                end else begin
                    r = finish(s, only, s.lstart, '0);
                end
            end
            default: begin
                r = finish(s, OC_NONE, pos, '0);
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lnls_scan.sv =====
// ----------------------------------------------------------------------------
// lnls_scan: per-line recognizer state and verdict formation
// Steps the line state once per accepted character and forms the verdict
// on the character marked last, then clears the line state.
// ----------------------------------------------------------------------------
`default_nettype none

module lnls_scan (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire lnls_pkg::t_item   i_item,
    input  wire logic [3:0]        i_max_digits,
    input  wire logic [5:0]        i_max_label,
    output logic                   o_res_valid,
    output lnls_pkg::t_result      o_res
);
    import lnls_pkg::*;

    t_line_state r_state;
    t_line_state n_state;
    t_line_state s_char;
    t_line_state s_end;
    t_cls        char_cls;

    // Step for the character itself, skipped once the verdict is decided.
    always_comb begin
        char_cls = ((i_item.ch == CH_NUL) || (r_state.position >= POS_LAST))
                   ? CL_OTHER : classify(i_item.ch);
        s_char = r_state;
        if (!r_state.decided) begin
            s_char = feed(r_state, char_cls, r_state.position, i_max_digits, i_max_label);
            if (r_state.position < POS_LAST) begin
                s_char.position = r_state.position + POS_W'(1);
            end
        end
    end

    // End of line acts as a terminator when nothing has been decided yet.
    always_comb begin
        s_end = s_char;
        if (!s_char.decided) begin
            s_end = feed(s_char, CL_OTHER, s_char.position, i_max_digits, i_max_label);
        end
    end

    // Verdict fields; offsets that do not apply to the outcome read as zero.
    always_comb begin
        o_res_valid        = i_accept && i_item.last;
        o_res.outcome      = s_end.oc;
        o_res.number_start = (s_end.oc == OC_NUM || s_end.oc == OC_BOTH || s_end.oc == OC_BAD)
                             ? s_end.nstart : '0;
        o_res.number_len   = (s_end.oc == OC_BAD) ? '0 : s_end.nlen;
        o_res.label_start  = (s_end.oc == OC_LABEL || s_end.oc == OC_BOTH)
                             ? s_end.lstart : '0;
        o_res.label_len    = s_end.llen;
        o_res.resume_pos   = s_end.resume;
    end

    // Next line state.
    always_comb begin
        n_state = r_state;
        if (i_accept) begin
            n_state = i_item.last ? LINE_RST : s_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LINE_RST;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lnls_skid.sv =====
// ----------------------------------------------------------------------------
// lnls_skid: two-entry result register with a registered stall
// An output register plus a skid entry so the scanner keeps taking
// characters while a verdict waits at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module lnls_skid (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire lnls_pkg::t_result i_data,
    output logic                   o_stall,
    output logic                   o_valid,
    output lnls_pkg::t_result      o_data,
    input  wire logic              i_stall
);
    import lnls_pkg::*;

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    n_out_valid;
    logic    n_skid_valid;
    t_result n_out;
    t_result n_skid;

    // Upstream only pushes while the skid entry is free.
    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Refill the output slot from the skid entry first, then from the input.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_valid;
                if (i_valid) begin
                    n_out = i_data;
                end
            end
        end else if (i_valid) begin
            n_skid       = i_data;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

`default_nettype wire

// ===== rtl/line_number_label_scanner.sv =====
// ----------------------------------------------------------------------------
// line_number_label_scanner: leading line number and label recognizer
// Scans one source line a character per transfer and reports one verdict
// per line with offsets, lengths and the resume position.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake               Payload
//   -------   ---------  ----------------------  ---------------------------
//   in        input      i_in_valid / o_in_stall  t_item   (ch, last)
//   out       output     o_out_valid / i_out_stall t_result (verdict)
//   cfg       input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One character is taken every cycle while the input is not stalled; each
// transfer updates the line state in a single registered step. The verdict of
// a line is formed from its last character and registered in the output buffer.
// Reset is synchronous and returns both limits to their defaults.
// Input stalls only while two verdicts are waiting in the output buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module line_number_label_scanner (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire lnls_pkg::t_item   i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output lnls_pkg::t_result      o_out_data,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_index,
    input  wire logic [5:0]        i_cfg_data
);
    import lnls_pkg::*;

    logic [3:0] r_max_digits;
    logic [5:0] r_max_label;
    logic       in_accept;
    logic       res_valid;
    t_result    res;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && !o_in_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_digits <= MAX_DIGITS_RST;
            r_max_label  <= MAX_LABEL_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_MAX_DIGITS: r_max_digits <= i_cfg_data[3:0];
                CFG_MAX_LABEL:  r_max_label  <= i_cfg_data;
                default:        r_max_label  <= r_max_label;
            endcase
        end
    end

    // Line recognizer.
    lnls_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_item       (i_in_data),
        .i_max_digits (r_max_digits),
        .i_max_label  (r_max_label),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // Verdict buffer toward the output channel.
    lnls_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .i_data  (res),
        .o_stall (o_in_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the line number and label scanner
// Feeds whole source lines a character per transfer, predicts each line's
// verdict with an independent scanner model, and compares every verdict
// field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    import lnls_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_CHARS = 230;

    // Clock, reset and block inputs, all known from time zero.
    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_in_valid  = 1'b0;
    t_item   i_in_data   = '0;
    logic    i_out_stall = 1'b0;
    logic    i_cfg_valid = 1'b0;
    logic    i_cfg_index = CFG_MAX_DIGITS;
    logic [5:0] i_cfg_data = '0;

    logic    o_in_stall;
    logic    o_out_valid;
    t_result o_out_data;
    logic    o_cfg_ready;

    // Characters waiting to be sent and verdicts waiting to arrive.
    t_item   pending_chars[$];
    t_result pending_verdicts[$];

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic in_taken       = 1'b0;
    int   stuck          = 0;
    int   error_count    = 0;

    // Scanner model: limits and per-line state.
    logic [3:0]       lim_digits;
    logic [5:0]       lim_label;
    t_phase           scan_phase;
    logic [POS_W-1:0] scan_pos;
    logic [5:0]       run_len;
    logic [POS_W-1:0] num_at;
    logic [3:0]       num_digits;
    logic [POS_W-1:0] lab_at;
    logic             line_done;
    logic [2:0]       held_oc;
    logic [POS_W-1:0] held_resume;
    logic [5:0]       held_llen;

    line_number_label_scanner u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Scanner model
    // ------------------------------------------------------------------

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls cl;
        cl = CL_OTHER;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
            cl = CL_WS;
        end else if (c >= CH_0 && c <= CH_9) begin
            cl = CL_DIGIT;
        end else if ((c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z)) begin
            cl = CL_ALPHA;
        end else if (c == CH_UNDER) begin
            cl = CL_UNDER;
        end else if (c == CH_COLON) begin
            cl = CL_COLON;
        end
        return cl;
    endfunction

    function automatic logic [2:0] plain_outcome();
        return (num_digits != '0) ? OC_NUM : OC_NONE;
    endfunction

    function automatic logic [2:0] labeled_outcome();
        return (num_digits != '0) ? OC_BOTH : OC_LABEL;
    endfunction

    task automatic clear_line();
        scan_phase  = PH_LEAD;
        scan_pos    = '0;
        run_len     = '0;
        num_at      = '0;
        num_digits  = '0;
        lab_at      = '0;
        line_done   = 1'b0;
        held_oc     = OC_NONE;
        held_resume = '0;
        held_llen   = '0;
    endtask

    // Once locked, the rest of the line has no effect.
    task automatic lock_verdict(input logic [2:0] oc, input logic [POS_W-1:0] at,
                                input logic [5:0] llen);
        line_done   = 1'b1;
        held_oc     = oc;
        held_resume = at;
        held_llen   = llen;
    endtask

    task automatic start_label(input logic [POS_W-1:0] pos);
        lab_at = pos;
        if (lim_label == '0) begin
            lock_verdict(plain_outcome(), pos, '0);
        end else begin
            run_len    = 6'd1;
            scan_phase = PH_LABEL;
        end
    endtask

    // One recognizer step for a character of the given class.
    task automatic scan_class(input t_cls cl, input logic [POS_W-1:0] pos);
        logic word_char;
        word_char = (cl == CL_ALPHA) || (cl == CL_DIGIT) || (cl == CL_UNDER);
        case (scan_phase)
            PH_LEAD: begin
                if (cl == CL_DIGIT) begin
                    num_at = pos;
                    if (lim_digits == '0) begin
                        lock_verdict(OC_BAD, pos, '0);
                    end else begin
                        run_len    = 6'd1;
                        scan_phase = PH_NUM;
                    end
                end else if (cl == CL_ALPHA) begin
                    start_label(pos);
                end else if (cl != CL_WS) begin
                    lock_verdict(OC_NONE, pos, '0);
                end
            end
            PH_NUM: begin
                if (cl == CL_DIGIT && run_len < {2'b00, lim_digits}) begin
                    run_len = run_len + 6'd1;
                end else if (cl == CL_WS) begin
                    num_digits = run_len[3:0];
                    run_len    = '0;
                    scan_phase = PH_GAP;
                end else begin
                    // Too many digits, or a digit run not ended by white space.
                    lock_verdict(OC_BAD, num_at, '0);
                end
            end
            PH_GAP: begin
                if (cl == CL_ALPHA) begin
                    start_label(pos);
                end else if (cl != CL_WS) begin
                    lock_verdict(plain_outcome(), pos, '0);
                end
            end
            PH_LABEL: begin
                if (word_char && run_len < lim_label) begin
                    run_len = run_len + 6'd1;
                end else if (cl == CL_WS) begin
                    scan_phase = PH_LTAIL;
                end else if (cl == CL_COLON) begin
                    lock_verdict(labeled_outcome(), pos + POS_W'(1), run_len);
                end else begin
                    lock_verdict(plain_outcome(), lab_at, '0);
                end
            end
            PH_LTAIL: begin
                if (cl == CL_COLON) begin
                    lock_verdict(labeled_outcome(), pos + POS_W'(1), run_len);
                end else if (cl != CL_WS) begin
                    lock_verdict(plain_outcome(), lab_at, '0);
                end
            end
            default: begin
                lock_verdict(OC_NONE, pos, '0);
            end
        endcase
    endtask

    // Advance the model by one accepted character; a line end yields a verdict.
    task automatic predict_char(input t_item it);
        t_cls    cl;
        t_result v;
        if (!line_done) begin
            // A NUL byte or an offset at the line limit acts as a terminator.
            cl = (it.ch == CH_NUL || scan_pos >= POS_LAST) ? CL_OTHER : char_class(it.ch);
            scan_class(cl, scan_pos);
            if (scan_pos < POS_LAST) begin
                scan_pos = scan_pos + POS_W'(1);
            end
        end
        if (it.last) begin
            if (!line_done) begin
                scan_class(CL_OTHER, scan_pos);
            end
            v            = '0;
            v.outcome    = held_oc;
            v.number_len = (held_oc == OC_BAD) ? 4'd0 : num_digits;
            v.label_len  = held_llen;
            v.resume_pos = held_resume;
            if (held_oc == OC_NUM || held_oc == OC_BOTH || held_oc == OC_BAD) begin
                v.number_start = num_at;
            end
            if (held_oc == OC_LABEL || held_oc == OC_BOTH) begin
                v.label_start = lab_at;
            end
            pending_verdicts.push_back(v);
            clear_line();
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: new characters and output stalls change on the falling edge.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            // A character is held until its transfer completes.
            if (!i_in_valid || in_taken) begin
                if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= pending_chars[0];
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on input transfers, checks output transfers, and
    // watches for a hang.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result want;
        logic    moved;
        moved = 1'b0;
        in_taken <= i_rst_n && i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                pending_chars.delete(0);
                predict_char(i_in_data);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_verdicts.size() == 0) begin
                    error_count++;
                    if (error_count <= 10) begin
                        $display("ERROR: verdict with none expected: oc=%0d ns=%0d nl=%0d ls=%0d ll=%0d rp=%0d",
                                 o_out_data.outcome, o_out_data.number_start,
                                 o_out_data.number_len, o_out_data.label_start,
                                 o_out_data.label_len, o_out_data.resume_pos);
                    end
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_out_data.outcome !== want.outcome
                        || o_out_data.number_start !== want.number_start
                        || o_out_data.number_len !== want.number_len
                        || o_out_data.label_start !== want.label_start
                        || o_out_data.label_len !== want.label_len
                        || o_out_data.resume_pos !== want.resume_pos) begin
                        error_count++;
                        if (error_count <= 10) begin
                            $display("ERROR: verdict mismatch at %0t", $realtime);
                            $display("  expected oc=%0d ns=%0d nl=%0d ls=%0d ll=%0d rp=%0d",
                                     want.outcome, want.number_start, want.number_len,
                                     want.label_start, want.label_len, want.resume_pos);
                            $display("  actual   oc=%0d ns=%0d nl=%0d ls=%0d ll=%0d rp=%0d",
                                     o_out_data.outcome, o_out_data.number_start,
                                     o_out_data.number_len, o_out_data.label_start,
                                     o_out_data.label_len, o_out_data.resume_pos);
                        end
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
            end
        end
        if (!i_rst_n || moved) begin
            stuck <= 0;
        end else if (stuck >= STALL_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] c, input logic last);
        pending_chars.push_back(t_item'{ch: c, last: last});
    endtask

    task automatic add_line(input string text);
        int i;
        for (i = 0; i < text.len(); i++) begin
            push_byte(text[i], i == text.len() - 1);
        end
    endtask

    function automatic logic [7:0] any_blank();
        logic [7:0] c;
        c = ($urandom_range(0, 2) == 0) ? CH_SPACE : CH_TAB + 8'($urandom_range(0, 4));
        return c;
    endfunction

    function automatic logic [7:0] any_letter();
        logic [7:0] c;
        c = ($urandom_range(0, 1) == 0) ? CH_UC_A : CH_LC_A;
        return c + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] any_word_char();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0: c = CH_UNDER;
            1, 2: c = CH_0 + 8'($urandom_range(0, 9));
            default: c = any_letter();
        endcase
        return c;
    endfunction

    // Mostly well-formed prefixes with random content; the rest is noise.
    task automatic add_random_line();
        logic [7:0] text[$];
        int n;
        int i;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 12);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(0, 2)) text.push_back(any_blank());
            if ($urandom_range(0, 3) != 0) begin
                repeat ($urandom_range(1, lim_digits + 1)) begin
                    text.push_back(CH_0 + 8'($urandom_range(0, 9)));
                end
                if ($urandom_range(0, 7) != 0) begin
                    repeat ($urandom_range(1, 2)) text.push_back(any_blank());
                end else begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 4) != 0) begin
                text.push_back(any_letter());
                repeat ($urandom_range(0, lim_label)) text.push_back(any_word_char());
                repeat ($urandom_range(0, 1)) text.push_back(any_blank());
                if ($urandom_range(0, 7) != 0) begin
                    text.push_back(CH_COLON);
                end else begin
                    text.push_back(8'($urandom_range(0, 255)));
                end
            end
            repeat ($urandom_range(0, 3)) text.push_back(8'($urandom_range(0, 255)));
            if (text.size() == 0) begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (i = 0; i < text.size(); i++) begin
            push_byte(text[i], i == text.size() - 1);
        end
    endtask

    // Wait until every character is sent and every verdict has arrived.
    task automatic drain();
        do @(negedge i_clk);
        while (pending_chars.size() != 0 || pending_verdicts.size() != 0);
    endtask

    task automatic write_limit(input logic idx, input logic [5:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MAX_DIGITS) begin
            lim_digits = value[3:0];
        end else begin
            lim_label = value;
        end
    endtask

    task automatic set_idling(input int mode);
        @(posedge i_clk);
        case (mode)
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            3: begin send_idle_pct = 7;  recv_stall_pct = 7;  end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        logic [3:0] digit_set[8];
        logic [5:0] label_set[8];
        int p;
        digit_set = '{4'd15, 4'd1, 4'd0, 4'd3, 4'd15, 4'd0, 4'd5, 4'd1};
        label_set = '{6'd63, 6'd1, 6'd0, 6'd10, 6'd1, 6'd63, 6'd31, 6'd20};
        lim_digits = MAX_DIGITS_RST;
        lim_label  = MAX_LABEL_RST;
        clear_line();

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed lines at the reset limits.
        set_idling(0);
        add_line("123 abc:");
        add_line("  42\tfoo_1 :");
        add_line("Lbl_9:");
        add_line("12");
        add_line("123456 x:");
        add_line("12a");
        add_line("7 9x");
        add_line("%x:");
        add_line("ab cd");
        add_line("1 ab");
        // Every white-space control code ahead of a label.
        push_byte(CH_TAB, 1'b0);
        push_byte(CH_TAB + 8'd1, 1'b0);
        push_byte(CH_TAB + 8'd2, 1'b0);
        push_byte(CH_TAB + 8'd3, 1'b0);
        push_byte(CH_CR, 1'b0);
        add_line("z :");
        // A NUL byte cuts the label off before its colon.
        push_byte(CH_LC_A, 1'b0);
        push_byte(CH_NUL, 1'b0);
        push_byte(CH_COLON, 1'b1);
        push_byte(CH_NUL, 1'b1);
        push_byte(8'hFF, 1'b1);
        drain();

        // Random phases, each at its own limits, cycling through four idling patterns.
        for (p = 0; p < 8; p++) begin
            repeat (4) @(negedge i_clk);
            write_limit(CFG_MAX_DIGITS, {2'($urandom_range(0, 3)), digit_set[p]});
            write_limit(CFG_MAX_LABEL, label_set[p]);
            set_idling(p % 4);
            while (pending_chars.size() < PHASE_CHARS) begin
                add_random_line();
            end
            drain();
        end

        repeat (8) @(negedge i_clk);
        if (pending_verdicts.size() != 0) begin
            $display("ERROR: %0d verdicts never arrived", pending_verdicts.size());
            error_count += pending_verdicts.size();
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
